[rtl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// Used by the sweep engine, the core and the testbench; no dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam logic [2:0] OP_WRITE     = 3'd0;
   localparam logic [2:0] OP_NEWLINE   = 3'd1;
   localparam logic [2:0] OP_BACKSPACE = 3'd2;
   localparam logic [2:0] OP_CLEAR     = 3'd3;
   localparam logic [2:0] OP_READ      = 3'd4;

   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] BLANK_ATTR = 8'h07;
   localparam logic [7:0] ERASE_ATTR = 8'h03;

   localparam int CELL_WIDTH = 16;

   localparam logic [CELL_WIDTH-1:0] BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};
   localparam logic [CELL_WIDTH-1:0] ERASE_CELL = {ERASE_ATTR, BLANK_CHAR};

   typedef struct packed {
      logic start;
      logic scroll;
   } sweep_cmd_type;

endpackage

[rtl/tcw_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tcw_sweep.sv]
// Screen sweep engine: walks the cell memory once for a scroll or a clear.
// Depends on tcw_pkg; drives the memory ports while busy.
`timescale 1ns / 1ps

module tcw_sweep #(
   parameter int COLUMNS = 80,
   parameter int ROWS_ON_SCREEN = 25,
   localparam int CELL_COUNT = COLUMNS * ROWS_ON_SCREEN,
   localparam int AW = $clog2(CELL_COUNT)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tcw_pkg::sweep_cmd_type         cmd,
   output logic                           busy,
   output logic                           rd_en,
   output logic [AW-1:0]                  rd_addr,
   input  logic [tcw_pkg::CELL_WIDTH-1:0] rd_data,
   output logic                           wr_en,
   output logic [AW-1:0]                  wr_addr,
   output logic [tcw_pkg::CELL_WIDTH-1:0] wr_data
);

   localparam logic [AW-1:0] KEEP_A = AW'(CELL_COUNT - COLUMNS);
   localparam logic [AW-1:0] LAST_A = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

   logic          running_ff;
   logic          scroll_ff;
   logic [AW-1:0] ptr_ff;
   logic          wr_valid_ff;
   logic [AW-1:0] wr_addr_ff;
   logic          wr_blank_ff;
   logic          copy_row;

   assign copy_row = scroll_ff && (ptr_ff < KEEP_A);

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b1;
         scroll_ff   <= 1'b0;
         ptr_ff      <= '0;
         wr_valid_ff <= 1'b0;
      end else begin
         wr_valid_ff <= running_ff;
         if (cmd.start) begin
            running_ff <= 1'b1;
            scroll_ff  <= cmd.scroll;
            ptr_ff     <= '0;
         end else if (running_ff) begin
            if (ptr_ff == LAST_A) begin
               running_ff <= 1'b0;
            end else begin
               ptr_ff <= ptr_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= ptr_ff;
      wr_blank_ff <= !copy_row;
   end

   assign busy    = running_ff || wr_valid_ff;
   assign rd_en   = running_ff && copy_row;
   assign rd_addr = ptr_ff + COLS_A;
   assign wr_en   = wr_valid_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = wr_blank_ff ? tcw_pkg::BLANK_CELL : rd_data;

endmodule

[rtl/text_console_writer_core.sv]
// Top level of the text console writer: cursor control, request decode and response.
// Depends on tcw_pkg, tcw_ram and tcw_sweep.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | operation, char_code, attribute, cell_index
//   rsp     | out       | rsp_valid / rsp_ready | cursor_position, read_char, read_attribute,
//           |           |                       | chars_written
//
// A write without wrap or a backspace answers from registers loaded when it is taken; a read
// first waits in ST_READ for the registered memory read port. Newline, clear and a write
// that wraps sweep the cell memory with one write per cycle; no request is taken until the
// sweep has finished. After reset the same sweep clears the cells;
// req_ready stays low until that sweep is done.
// A new request is taken when no response waits or the waiting one leaves in the same
// cycle, and no sweep or read is running.
`timescale 1ns / 1ps

module text_console_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS_ON_SCREEN = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_attribute,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_cursor_position,
   output logic [7:0]  rsp_read_char,
   output logic [7:0]  rsp_read_attribute,
   output logic        rsp_chars_written
);

   localparam int CELL_COUNT = COLUMNS * ROWS_ON_SCREEN;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int CW = $clog2(COLUMNS);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS_ON_SCREEN - 1) * COLUMNS);
   localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
   localparam logic [CW:0]   COLS_C = (CW + 1)'(COLUMNS);
   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP
   } state_type;

   state_type                     state_ff;
   logic [CW-1:0]                 col_ff, col_in;
   logic [AW-1:0]                 row_base_ff, row_base_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic                          in_range_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [10:0]                   rsp_pos_ff;
   logic [7:0]                    rsp_char_ff;
   logic [7:0]                    rsp_attr_ff;
   logic                          rsp_wrote_ff;

   logic                          accept;
   logic                          at_origin;
   logic [CW:0]                   col_inc;
   logic                          wrap;
   logic [AW+10:0]                idx_wide;
   logic [AW+10:0]                pos_wide;
   logic [AW+10:0]                pos_in_wide;
   logic                          idx_in_range;
   logic                          top_wr_en;
   logic [AW-1:0]                 top_wr_addr;
   logic [tcw_pkg::CELL_WIDTH-1:0] top_wr_data;
   logic                          top_rd_en;

   tcw_pkg::sweep_cmd_type        sweep_cmd;
   logic                          sweep_busy;
   logic                          sw_rd_en;
   logic [AW-1:0]                 sw_rd_addr;
   logic                          sw_wr_en;
   logic [AW-1:0]                 sw_wr_addr;
   logic [tcw_pkg::CELL_WIDTH-1:0] sw_wr_data;

   logic                          mem_wr_en;
   logic [AW-1:0]                 mem_wr_addr;
   logic [tcw_pkg::CELL_WIDTH-1:0] mem_wr_data;
   logic                          mem_rd_en;
   logic [AW-1:0]                 mem_rd_addr;
   logic [tcw_pkg::CELL_WIDTH-1:0] mem_rd_data;

   assign req_ready    = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept       = req_valid && req_ready;
   assign at_origin    = (col_ff == '0) && (row_base_ff == '0);
   assign col_inc      = {1'b0, col_ff} + (CW + 1)'(1);
   assign wrap         = (col_inc == COLS_C);
   assign idx_wide     = {{AW{1'b0}}, req_cell_index};
   assign pos_wide     = {11'b0, pos_ff};
   assign pos_in_wide  = {11'b0, pos_in};
   assign idx_in_range = idx_wide < (AW + 11)'(CELL_COUNT);
   assign rsp_valid_in = (state_ff == ST_READ)
                         || (accept && (req_operation != tcw_pkg::OP_READ))
                         || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      col_in      = col_ff;
      row_base_in = row_base_ff;
      pos_in      = pos_ff;
      top_wr_en   = 1'b0;
      top_wr_addr = pos_ff;
      top_wr_data = {req_attribute, req_char_code};
      top_rd_en   = 1'b0;
      sweep_cmd   = '{start: 1'b0, scroll: 1'b1};
      case (req_operation)
         tcw_pkg::OP_WRITE: begin
            top_wr_en = accept;
            if (wrap) begin
               col_in          = '0;
               pos_in          = row_base_ff;
               sweep_cmd.start = accept;
            end else begin
               col_in = col_inc[CW-1:0];
               pos_in = pos_ff + AW'(1);
            end
         end
         tcw_pkg::OP_NEWLINE: begin
            col_in          = '0;
            pos_in          = row_base_ff;
            sweep_cmd.start = accept;
         end
         tcw_pkg::OP_BACKSPACE: begin
            if (!at_origin) begin
               pos_in      = pos_ff - AW'(1);
               top_wr_en   = accept;
               top_wr_addr = pos_ff - AW'(1);
               top_wr_data = tcw_pkg::ERASE_CELL;
               if (col_ff == '0) begin
                  col_in      = LAST_COL;
                  row_base_in = row_base_ff - COLS_A;
               end else begin
                  col_in = col_ff - CW'(1);
               end
            end
         end
         tcw_pkg::OP_CLEAR: begin
            sweep_cmd.start  = accept;
            sweep_cmd.scroll = 1'b0;
         end
         tcw_pkg::OP_READ: begin
            top_rd_en = accept;
         end
         default: begin
         end
      endcase
   end

   assign mem_wr_en   = sw_wr_en || top_wr_en;
   assign mem_wr_addr = sw_wr_en ? sw_wr_addr : top_wr_addr;
   assign mem_wr_data = sw_wr_en ? sw_wr_data : top_wr_data;
   assign mem_rd_en   = sw_rd_en || top_rd_en;
   assign mem_rd_addr = sw_rd_en ? sw_rd_addr : idx_wide[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_base_ff  <= LAST_ROW_BASE;
         pos_ff       <= LAST_ROW_BASE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  col_ff      <= col_in;
                  row_base_ff <= row_base_in;
                  pos_ff      <= pos_in;
                  in_range_ff <= idx_in_range;
                  if (req_operation == tcw_pkg::OP_READ) begin
                     state_ff <= ST_READ;
                  end else begin
                     rsp_pos_ff   <= pos_in_wide[10:0];
                     rsp_char_ff  <= '0;
                     rsp_attr_ff  <= '0;
                     rsp_wrote_ff <= (req_operation == tcw_pkg::OP_WRITE);
                     if (sweep_cmd.start) begin
                        state_ff <= ST_SWEEP;
                     end
                  end
               end
            end
            ST_READ: begin
               rsp_pos_ff   <= pos_wide[10:0];
               rsp_char_ff  <= in_range_ff ? mem_rd_data[7:0] : 8'h00;
               rsp_attr_ff  <= in_range_ff ? mem_rd_data[15:8] : 8'h00;
               rsp_wrote_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
            ST_SWEEP: begin
               if (!sweep_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_read_char       = rsp_char_ff;
   assign rsp_read_attribute  = rsp_attr_ff;
   assign rsp_chars_written   = rsp_wrote_ff;

   tcw_sweep #(
      .COLUMNS        (COLUMNS),
      .ROWS_ON_SCREEN (ROWS_ON_SCREEN)
   ) u_sweep (
      .clock   (clock),
      .reset   (reset),
      .cmd     (sweep_cmd),
      .busy    (sweep_busy),
      .rd_en   (sw_rd_en),
      .rd_addr (sw_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (sw_wr_en),
      .wr_addr (sw_wr_addr),
      .wr_data (sw_wr_data)
   );

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_WIDTH),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

[rtl/tcw_checker.sv]
// Port-level checks for the text console writer, bound to the top level.
// Depends on text_console_writer_core.
`timescale 1ns / 1ps

module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS_ON_SCREEN = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_cursor_position,
   input logic [7:0]  rsp_read_char,
   input logic [7:0]  rsp_read_attribute,
   input logic        rsp_chars_written
);

   localparam int CELL_COUNT = COLUMNS * ROWS_ON_SCREEN;

   // The cell memory is cleared after reset, so no request is taken right away.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during the clearing pass");

   // A write request never reports cell contents.
   a_write_no_read_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_chars_written) |-> (rsp_read_char == 8'h00 && rsp_read_attribute == 8'h00))
      else $error("write response carries read data");

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_position) < 32'(CELL_COUNT) || CELL_COUNT > 2048))
      else $error("cursor position off screen");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cursor_position)
         && $stable(rsp_read_char) && $stable(rsp_read_attribute)
         && $stable(rsp_chars_written)))
      else $error("response changed while stalled");

endmodule

bind text_console_writer_core tcw_checker #(
   .COLUMNS        (COLUMNS),
   .ROWS_ON_SCREEN (ROWS_ON_SCREEN)
) u_tcw_checker (.*);

[sim/text_console_writer_core_tb.sv]
// Self-checking testbench for text_console_writer_core: random and directed requests with
// a scoreboard that tracks the screen cells and cursor and checks every response.
// Depends on rtl/tcw_pkg.sv and the text_console_writer_core RTL.
`timescale 1ns / 1ps

module text_console_writer_core_tb;

   localparam int COLUMNS = 80;
   localparam int ROWS_ON_SCREEN = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS_ON_SCREEN;
   localparam int INDEX_MAX = 2047;
   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_REQUESTS = 1350;
   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_TAIL = CELL_COUNT + 100;
   localparam logic [2:0] OP_RESERVED_LO = 3'd5;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;

   typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_SELDOM} ready_mode_type;

   typedef struct {
      logic [10:0] position;
      logic [7:0]  rd_char;
      logic [7:0]  rd_attr;
      logic        wrote;
   } screen_result_type;

   class screen_scoreboard;
      logic [tcw_pkg::CELL_WIDTH-1:0] cells [CELL_COUNT];
      int unsigned column;
      int unsigned row;
      screen_result_type awaited [$];
      int unsigned errors;
      int unsigned checked;
      int unsigned scrolls;
      int unsigned corner_hits;
      int unsigned op_seen [8];

      function new();
         foreach (cells[i]) cells[i] = tcw_pkg::BLANK_CELL;
         foreach (op_seen[i]) op_seen[i] = 0;
         column = 0;
         row = ROWS_ON_SCREEN - 1;
         errors = 0;
         checked = 0;
         scrolls = 0;
         corner_hits = 0;
      endfunction

      function int unsigned cursor_index();
         return row * COLUMNS + column;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      function void scroll_screen();
         for (int i = 0; i < CELL_COUNT - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
         for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) cells[i] = tcw_pkg::BLANK_CELL;
         column = 0;
         scrolls++;
      endfunction

      function void note_request(logic [2:0] op, logic [7:0] ch, logic [7:0] at,
                                 logic [10:0] idx);
         screen_result_type r;
         r.rd_char = '0;
         r.rd_attr = '0;
         r.wrote = 1'b0;
         op_seen[op]++;
         case (op)
            tcw_pkg::OP_WRITE: begin
               cells[cursor_index()] = {at, ch};
               column++;
               if (column >= COLUMNS) scroll_screen();
               r.wrote = 1'b1;
            end
            tcw_pkg::OP_NEWLINE: scroll_screen();
            tcw_pkg::OP_BACKSPACE: begin
               if (column == 0 && row == 0) begin
                  corner_hits++;
               end else begin
                  if (column == 0) begin
                     column = COLUMNS - 1;
                     row--;
                  end else begin
                     column--;
                  end
                  cells[cursor_index()] = tcw_pkg::ERASE_CELL;
               end
            end
            tcw_pkg::OP_CLEAR: foreach (cells[i]) cells[i] = tcw_pkg::BLANK_CELL;
            tcw_pkg::OP_READ: begin
               if (idx < CELL_COUNT) {r.rd_attr, r.rd_char} = cells[idx];
            end
            default: ;
         endcase
         r.position = 11'(cursor_index());
         awaited.push_back(r);
      endfunction

      function void compare_field(string field, logic [10:0] want, logic [10:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [10:0] pos, logic [7:0] rc, logic [7:0] ra,
                                   logic cw);
         screen_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual position %0d",
                     $time, pos);
            errors++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         compare_field("cursor_position", want.position, pos);
         compare_field("read_char", 11'(want.rd_char), 11'(rc));
         compare_field("read_attribute", 11'(want.rd_attr), 11'(ra));
         compare_field("chars_written", 11'(want.wrote), 11'(cw));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = '0;
   logic [7:0]  req_char_code = '0;
   logic [7:0]  req_attribute = '0;
   logic [10:0] req_cell_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [10:0] rsp_cursor_position;
   logic [7:0]  rsp_read_char;
   logic [7:0]  rsp_read_attribute;
   logic        rsp_chars_written;

   screen_scoreboard sb = new();
   int unsigned quiet_cycles = 0;
   int unsigned burst_left = 0;
   int unsigned ready_phase = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   text_console_writer_core #(
      .COLUMNS(COLUMNS),
      .ROWS_ON_SCREEN(ROWS_ON_SCREEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_char_code(req_char_code),
      .req_attribute(req_attribute),
      .req_cell_index(req_cell_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cursor_position(rsp_cursor_position),
      .rsp_read_char(rsp_read_char),
      .rsp_read_attribute(rsp_read_attribute),
      .rsp_chars_written(rsp_chars_written)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (ready_phase == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(READY_ALWAYS, READY_SELDOM));
         ready_phase <= $urandom_range(50, 400);
      end else begin
         ready_phase <= ready_phase - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         default:      rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_cursor_position, rsp_read_char, rsp_read_attribute,
                              rsp_chars_written);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Timeout: no request or response moved for %0d cycles.", QUIET_LIMIT);
      $display("text_console_writer_core_tb NOT OK");
      $finish;
   end

   // Called at a rising edge; returns at the edge where the request is accepted.
   task automatic send_request(input logic [2:0] op, input logic [7:0] ch,
                               input logic [7:0] at, input logic [10:0] idx);
      req_valid <= 1'b1;
      req_operation <= op;
      req_char_code <= ch;
      req_attribute <= at;
      req_cell_index <= idx;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      sb.note_request(op, ch, at, idx);
   endtask

   task automatic idle_cycles(input int unsigned count);
      req_valid <= 1'b0;
      repeat (count) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic paced_request(input logic [2:0] op, input logic [7:0] ch,
                                input logic [7:0] at, input logic [10:0] idx);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      send_request(op, ch, at, idx);
   endtask

   task automatic random_request();
      int unsigned pick;
      int near;
      logic [2:0] op;
      logic [10:0] idx;
      pick = $urandom_range(0, 99);
      idx = 11'($urandom_range(0, INDEX_MAX));
      if (pick < 45) begin
         op = tcw_pkg::OP_WRITE;
      end else if (pick < 70) begin
         op = tcw_pkg::OP_READ;
         if ($urandom_range(0, 1) == 1) begin
            near = int'(sb.cursor_index()) + int'($urandom_range(0, 160)) - 100;
            if (near < 0) near = 0;
            if (near > INDEX_MAX) near = INDEX_MAX;
            idx = 11'(near);
         end
      end else if (pick < 88) begin
         op = tcw_pkg::OP_BACKSPACE;
      end else if (pick < 92) begin
         op = tcw_pkg::OP_NEWLINE;
      end else if (pick < 94) begin
         op = tcw_pkg::OP_CLEAR;
      end else begin
         op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      end
      paced_request(op, 8'($urandom), 8'($urandom), idx);
   endtask

   initial begin
      int unsigned bottom;
      int unsigned others;
      bottom = (ROWS_ON_SCREEN - 1) * COLUMNS;
      others = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd0);
      paced_request(tcw_pkg::OP_READ, 8'hFF, 8'hFF, 11'(CELL_COUNT - 1));
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(CELL_COUNT));
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(INDEX_MAX));
      paced_request(tcw_pkg::OP_WRITE, 8'h00, 8'h00, 11'd0);
      paced_request(tcw_pkg::OP_WRITE, 8'hFF, 8'hFF, 11'(INDEX_MAX));
      paced_request(tcw_pkg::OP_WRITE, 8'hA5, 8'h5A, 11'd0);
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(bottom));
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(bottom + 1));
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(bottom + 2));
      paced_request(tcw_pkg::OP_BACKSPACE, 8'h00, 8'h00, 11'd0);
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(bottom + 2));
      paced_request(tcw_pkg::OP_NEWLINE, 8'hFF, 8'hFF, 11'(INDEX_MAX));
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(bottom));
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(bottom - COLUMNS + 1));
      // Backspace at column 0 wraps to the last column of the row above.
      paced_request(tcw_pkg::OP_BACKSPACE, 8'h00, 8'h00, 11'd0);
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(bottom - 1));
      paced_request(tcw_pkg::OP_CLEAR, 8'h00, 8'h00, 11'd0);
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(bottom - COLUMNS + 1));
      for (int op = OP_RESERVED_LO; op <= OP_RESERVED_HI; op++) begin
         paced_request(3'(op), 8'hFF, 8'hFF, 11'(INDEX_MAX));
      end
      paced_request(tcw_pkg::OP_WRITE, 8'h41, 8'h1E, 11'd0);
      paced_request(tcw_pkg::OP_READ, 8'h00, 8'h00, 11'(bottom - 1));

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 2) wait_drained();
         random_request();
      end

      // Walk the cursor up to the top-left corner one row at a time, then push against it.
      wait_drained();
      paced_request(tcw_pkg::OP_NEWLINE, 8'($urandom), 8'($urandom), 11'($urandom));
      while (sb.row != 0) begin
         paced_request(tcw_pkg::OP_BACKSPACE, 8'($urandom), 8'($urandom), 11'($urandom));
         paced_request(tcw_pkg::OP_NEWLINE, 8'($urandom), 8'($urandom), 11'($urandom));
      end
      repeat (3) begin
         paced_request(tcw_pkg::OP_BACKSPACE, 8'($urandom), 8'($urandom), 11'($urandom));
      end
      repeat (100) random_request();

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);

      for (int op = OP_RESERVED_LO; op <= OP_RESERVED_HI; op++) begin
         others += sb.op_seen[op];
      end
      $display("Sent %0d writes, %0d reads, %0d backspaces, %0d newlines, %0d clears, %0d other.",
               sb.op_seen[tcw_pkg::OP_WRITE], sb.op_seen[tcw_pkg::OP_READ],
               sb.op_seen[tcw_pkg::OP_BACKSPACE], sb.op_seen[tcw_pkg::OP_NEWLINE],
               sb.op_seen[tcw_pkg::OP_CLEAR], others);
      $display("Checked %0d responses over %0d scrolls; backspace held at the corner %0d times.",
               sb.checked, sb.scrolls, sb.corner_hits);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("text_console_writer_core_tb OK");
      end else begin
         $display("%0d mismatches, %0d responses missing.", sb.errors, sb.pending());
         $display("text_console_writer_core_tb NOT OK");
      end
      $finish;
   end

endmodule
